// File: design/rcl_pkg.sv
// ----------------------------------------------------------------------------
// rcl_pkg
// Shared types and constants for the ranked contribution list core.
// ----------------------------------------------------------------------------
package rcl_pkg;

  localparam int unsigned ListDepthDef = 10;

  localparam int unsigned TrackW  = 24;
  localparam int unsigned HitW    = 24;
  localparam int unsigned AmountW = 32;
  localparam int unsigned SumW    = 40;
  localparam int unsigned UsedW   = 5;
  localparam int unsigned FuncW   = 2;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 208;

  typedef enum logic [FuncW-1:0] {
    FUNC_SIGNAL = 2'd0,
    FUNC_NOISE  = 2'd1,
    FUNC_ELECT  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef struct packed {
    logic load_item;
    logic prep;
    logic update;
    logic load_out;
  } cmd_t;

endpackage

// File: design/rcl_ctrl.sv
// ----------------------------------------------------------------------------
// rcl_ctrl
// Sequencer: capture beat, match/accumulate, list update, result load.
// ----------------------------------------------------------------------------
module rcl_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output rcl_pkg::cmd_t cmd_o
);
  import rcl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_UPD,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   m_tvalid_q, m_tvalid_d;
  logic   out_free;

  assign out_free = !m_tvalid_q || m_tready_i;

  always_comb begin
    state_d    = state_q;
    m_tvalid_d = m_tvalid_q && !m_tready_i;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          m_tvalid_d     = 1'b1;
          s_tready_o     = 1'b1;
          if (s_tvalid_i) begin
            cmd_o.load_item = 1'b1;
            state_d         = ST_PREP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  assign m_tvalid_o = m_tvalid_q;

endmodule

// File: design/rcl_dpath.sv
// ----------------------------------------------------------------------------
// rcl_dpath
// Sorted entry list with compare-shift slots, saturating totals and the
// result register.
// ----------------------------------------------------------------------------
module rcl_dpath #(
  parameter int unsigned LIST_DEPTH = rcl_pkg::ListDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rcl_pkg::cmd_t                       cmd_i,
  input  logic [rcl_pkg::FuncW-1:0]           func_i,
  input  logic [rcl_pkg::TrackW-1:0]          track_i,
  input  logic [rcl_pkg::HitW-1:0]            hit_i,
  input  logic signed [rcl_pkg::AmountW-1:0]  amount_i,
  output logic                                top_valid_o,
  output logic [rcl_pkg::TrackW-1:0]          top_track_o,
  output logic [rcl_pkg::HitW-1:0]            top_hit_o,
  output logic signed [rcl_pkg::AmountW-1:0]  top_amount_o,
  output logic [rcl_pkg::UsedW-1:0]           used_entries_o,
  output logic signed [rcl_pkg::SumW-1:0]     total_signal_o,
  output logic signed [rcl_pkg::SumW-1:0]     noise_sum_o,
  output logic signed [rcl_pkg::SumW-1:0]     elect_sum_o
);
  import rcl_pkg::*;

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(LIST_DEPTH);

  function automatic logic signed [AmountW-1:0] sat_add_amt(
    input logic signed [AmountW-1:0] a,
    input logic signed [AmountW-1:0] b
  );
    logic signed [AmountW:0] s;
    s = (AmountW+1)'(a) + (AmountW+1)'(b);
    if (s[AmountW] != s[AmountW-1]) begin
      sat_add_amt = {s[AmountW], {(AmountW-1){~s[AmountW]}}};
    end else begin
      sat_add_amt = s[AmountW-1:0];
    end
  endfunction

  function automatic logic signed [SumW-1:0] sat_add_sum(
    input logic signed [SumW-1:0]    a,
    input logic signed [AmountW-1:0] b
  );
    logic signed [SumW:0] s;
    s = (SumW+1)'(a) + (SumW+1)'(b);
    if (s[SumW] != s[SumW-1]) begin
      sat_add_sum = {s[SumW], {(SumW-1){~s[SumW]}}};
    end else begin
      sat_add_sum = s[SumW-1:0];
    end
  endfunction

  // item registers
  func_e                     func_q;
  logic [TrackW-1:0]         itrk_q;
  logic [HitW-1:0]           ihit_q;
  logic signed [AmountW-1:0] iamt_q;

  // match stage
  logic [LIST_DEPTH-1:0]     match_q, match_d;
  logic                      found_q;
  logic signed [AmountW-1:0] acc_q, acc_d;
  logic [HitW-1:0]           acc_hit_q, acc_hit_d;
  logic signed [AmountW-1:0] mamt;

  // list and totals
  logic [TrackW-1:0]         trk_q [LIST_DEPTH];
  logic [HitW-1:0]           hit_q [LIST_DEPTH];
  logic signed [AmountW-1:0] amt_q [LIST_DEPTH];
  logic [TrackW-1:0]         trk_d [LIST_DEPTH];
  logic [HitW-1:0]           hit_d [LIST_DEPTH];
  logic signed [AmountW-1:0] amt_d [LIST_DEPTH];
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic signed [SumW-1:0]    sig_q, sig_d, noi_q, noi_d, ele_q, ele_d;
  logic                      list_we;

  // update stage
  logic signed [AmountW-1:0] ins_amt;
  logic [HitW-1:0]           ins_hit;
  logic [LIST_DEPTH-1:0]     lt_m, ahead;
  logic                      lt_acc, do_ins;
  logic [CntW-1:0]           pos;
  logic [TrackW-1:0]         oth_trk [LIST_DEPTH];
  logic [HitW-1:0]           oth_hit [LIST_DEPTH];
  logic signed [AmountW-1:0] oth_amt [LIST_DEPTH];
  logic [TrackW-1:0]         dn_trk [LIST_DEPTH];
  logic [HitW-1:0]           dn_hit [LIST_DEPTH];
  logic signed [AmountW-1:0] dn_amt [LIST_DEPTH];

  // result register
  logic                      out_vld_q;
  logic [TrackW-1:0]         out_trk_q;
  logic [HitW-1:0]           out_hit_q;
  logic signed [AmountW-1:0] out_amt_q;
  logic [UsedW-1:0]          out_used_q;
  logic signed [SumW-1:0]    out_sig_q, out_noi_q, out_ele_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q <= func_e'(func_i);
      itrk_q <= track_i;
      ihit_q <= hit_i;
      iamt_q <= amount_i;
    end
  end

  // track match and accumulate
  always_comb begin
    mamt      = '0;
    acc_hit_d = '0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      match_d[k] = (CntW'(k) < cnt_q) && (trk_q[k] == itrk_q);
      if (match_d[k]) begin
        mamt      = mamt | amt_q[k];
        acc_hit_d = acc_hit_d | hit_q[k];
      end
    end
    acc_d = sat_add_amt(mamt, iamt_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      match_q   <= match_d;
      found_q   <= |match_d;
      acc_q     <= acc_d;
      acc_hit_q <= acc_hit_d;
    end
  end

  // placement: drop the matched slot, rank the new value among the rest
  always_comb begin
    ins_amt = found_q ? acc_q : iamt_q;
    ins_hit = found_q ? acc_hit_q : ihit_q;
    lt_acc  = !found_q;
    for (int j = LIST_DEPTH - 1; j >= 0; j--) begin
      lt_m[j] = lt_acc;
      lt_acc  = lt_acc | match_q[j];
    end
    for (int j = 0; j < LIST_DEPTH; j++) begin
      ahead[j] = (CntW'(j) < cnt_q) && !match_q[j] &&
                 ((amt_q[j] > ins_amt) || ((amt_q[j] == ins_amt) && lt_m[j]));
    end
    pos    = CntW'($countones(ahead));
    do_ins = found_q || (cnt_q != Full) || (ins_amt > amt_q[LIST_DEPTH-1]);

    for (int k = 0; k < LIST_DEPTH - 1; k++) begin
      oth_trk[k] = lt_m[k] ? trk_q[k] : trk_q[k+1];
      oth_hit[k] = lt_m[k] ? hit_q[k] : hit_q[k+1];
      oth_amt[k] = lt_m[k] ? amt_q[k] : amt_q[k+1];
    end
    oth_trk[LIST_DEPTH-1] = trk_q[LIST_DEPTH-1];
    oth_hit[LIST_DEPTH-1] = hit_q[LIST_DEPTH-1];
    oth_amt[LIST_DEPTH-1] = amt_q[LIST_DEPTH-1];

    dn_trk[0] = oth_trk[0];
    dn_hit[0] = oth_hit[0];
    dn_amt[0] = oth_amt[0];
    for (int k = 1; k < LIST_DEPTH; k++) begin
      dn_trk[k] = oth_trk[k-1];
      dn_hit[k] = oth_hit[k-1];
      dn_amt[k] = oth_amt[k-1];
    end

    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (CntW'(k) < pos) begin
        trk_d[k] = oth_trk[k];
        hit_d[k] = oth_hit[k];
        amt_d[k] = oth_amt[k];
      end else if (CntW'(k) == pos) begin
        trk_d[k] = itrk_q;
        hit_d[k] = ins_hit;
        amt_d[k] = ins_amt;
      end else begin
        trk_d[k] = dn_trk[k];
        hit_d[k] = dn_hit[k];
        amt_d[k] = dn_amt[k];
      end
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    sig_d   = sig_q;
    noi_d   = noi_q;
    ele_d   = ele_q;
    list_we = 1'b0;
    case (func_q)
      FUNC_SIGNAL: begin
        sig_d   = sat_add_sum(sig_q, iamt_q);
        list_we = do_ins;
        if (do_ins && !found_q && (cnt_q != Full)) begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      FUNC_NOISE: begin
        noi_d = sat_add_sum(noi_q, iamt_q);
      end
      FUNC_ELECT: begin
        ele_d = sat_add_sum(ele_q, iamt_q);
      end
      FUNC_CLEAR: begin
        cnt_d = '0;
        sig_d = '0;
        noi_d = '0;
        ele_d = '0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sig_q <= '0;
      noi_q <= '0;
      ele_q <= '0;
    end else if (cmd_i.update) begin
      cnt_q <= cnt_d;
      sig_q <= sig_d;
      noi_q <= noi_d;
      ele_q <= ele_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && list_we) begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
        trk_q[k] <= trk_d[k];
        hit_q[k] <= hit_d[k];
        amt_q[k] <= amt_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_vld_q  <= (cnt_q != '0);
      out_trk_q  <= (cnt_q != '0) ? trk_q[0] : '0;
      out_hit_q  <= (cnt_q != '0) ? hit_q[0] : '0;
      out_amt_q  <= (cnt_q != '0) ? amt_q[0] : '0;
      out_used_q <= UsedW'(cnt_q);
      out_sig_q  <= sig_q;
      out_noi_q  <= noi_q;
      out_ele_q  <= ele_q;
    end
  end

  assign top_valid_o    = out_vld_q;
  assign top_track_o    = out_trk_q;
  assign top_hit_o      = out_hit_q;
  assign top_amount_o   = out_amt_q;
  assign used_entries_o = out_used_q;
  assign total_signal_o = out_sig_q;
  assign noise_sum_o    = out_noi_q;
  assign elect_sum_o    = out_ele_q;

endmodule

// File: design/ranked_contribution_list_core.sv
// ----------------------------------------------------------------------------
// ranked_contribution_list_core
// Per-cell contribution list kept in descending amount order, plus
// saturating signal, noise and post-electronics totals.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                               tuser
//  s_axis    in   track, hit, amount (80 b)           func (2 b)
//  m_axis    out  top_track, top_hit, top_amount,     top_valid (1 b)
//                 used_entries, total_signal,
//                 noise_sum, elect_sum (208 b)
//
//  One beat in, one beat out. The result is ready after the match/accumulate,
//  list compare-shift and result-load steps; the next beat is taken in the
//  result-load cycle, so no beat is taken while the last is still in work.
//  The list is updated at most once per signal beat, in a single compare-shift
//  across all slots. Reset empties the list and zeroes the totals.
//  An output stall holds the core in its result-load cycle.
// ----------------------------------------------------------------------------
module ranked_contribution_list_core #(
  parameter int unsigned LIST_DEPTH = rcl_pkg::ListDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rcl_pkg::InDataW-1:0]    s_axis_tdata,  // track, hit, amount
  input  logic [rcl_pkg::FuncW-1:0]      s_axis_tuser,  // func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // top_track, top_hit, top_amount, used_entries, total_signal, noise_sum,
  // elect_sum, zero pad
  output logic [rcl_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                           m_axis_tuser   // top_valid
);
  import rcl_pkg::*;

  cmd_t                      cmd;
  logic                      top_valid;
  logic [TrackW-1:0]         top_track;
  logic [HitW-1:0]           top_hit;
  logic signed [AmountW-1:0] top_amount;
  logic [UsedW-1:0]          used_entries;
  logic signed [SumW-1:0]    total_signal, noise_sum, elect_sum;

  rcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  rcl_dpath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (s_axis_tuser),
    .track_i        (s_axis_tdata[23:0]),
    .hit_i          (s_axis_tdata[47:24]),
    .amount_i       (s_axis_tdata[79:48]),
    .top_valid_o    (top_valid),
    .top_track_o    (top_track),
    .top_hit_o      (top_hit),
    .top_amount_o   (top_amount),
    .used_entries_o (used_entries),
    .total_signal_o (total_signal),
    .noise_sum_o    (noise_sum),
    .elect_sum_o    (elect_sum)
  );

  assign m_axis_tdata = {3'b000, elect_sum, noise_sum, total_signal, used_entries,
                         top_amount, top_hit, top_track};
  assign m_axis_tuser = top_valid;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("core took a beat while still working on the previous one");

  a_top_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[84:80] != 5'd0)))
    else $error("top_valid disagrees with used_entries");

  a_empty_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[79:0] == 80'd0))
    else $error("empty list reports a nonzero top entry");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[84:80] <= UsedW'(LIST_DEPTH)))
    else $error("used_entries beyond list depth");
`endif

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ranked_contribution_list_core. A scoreboard class
// models the cell (sorted top list, saturating totals) and queues one
// expected result beat per accepted input beat. Output beats are compared
// field by field. Stimulus is a short directed pass over the corner cases,
// then random traffic with a small track pool, saturation runs and clears.
// The sender works in bursts and the receiver stalls on its own pattern,
// including one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rcl_pkg::*;

  localparam int unsigned Depth       = ListDepthDef;
  localparam longint      AmtMax      = 64'sd2147483647;
  localparam longint      AmtMin      = -AmtMax - 1;
  localparam longint      SumMax      = 64'sd549755813887;
  localparam longint      SumMin      = -SumMax - 1;
  localparam int unsigned RandomItems = 1700;
  localparam int unsigned PoolSize    = 14;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned CycleLimit  = 600000;

  typedef struct {
    logic                top_valid;
    logic [TrackW-1:0]   top_track;
    logic [HitW-1:0]     top_hit;
    logic [AmountW-1:0]  top_amount;
    logic [UsedW-1:0]    used;
    logic [SumW-1:0]     total;
    logic [SumW-1:0]     noise;
    logic [SumW-1:0]     elect;
  } cell_view_t;

  class cell_scoreboard;
    logic [TrackW-1:0] trk_q [Depth];
    logic [HitW-1:0]   hit_q [Depth];
    longint            amt_q [Depth];
    bit                vld_q [Depth];
    longint            sig_acc;
    longint            noise_acc;
    longint            elect_acc;
    cell_view_t        expected_cells [$];
    int unsigned       errors;

    function new();
      clear_cell();
      errors = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned held();
      int unsigned n;
      n = 0;
      while (n < Depth && vld_q[n]) n++;
      return n;
    endfunction

    function void clear_cell();
      for (int i = 0; i < Depth; i++) begin
        trk_q[i] = '0;
        hit_q[i] = '0;
        amt_q[i] = 0;
        vld_q[i] = 1'b0;
      end
      sig_acc   = 0;
      noise_acc = 0;
      elect_acc = 0;
    endfunction

    function void add_signal(logic [TrackW-1:0] trk, logic [HitW-1:0] ht, longint a);
      int unsigned       n, pos, last, j;
      bit                found;
      logic [TrackW-1:0] tt;
      logic [HitW-1:0]   th;
      longint            ta;
      n       = held();
      sig_acc = clamp(sig_acc + a, SumMin, SumMax);
      found   = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (trk_q[i] == trk) begin
          amt_q[i] = clamp(amt_q[i] + a, AmtMin, AmtMax);
          found    = 1'b1;
        end
      end
      if (found) begin
        // stable insertion sort, descending
        for (int i = 1; i < n; i++) begin
          j = i;
          while (j > 0 && amt_q[j] > amt_q[j-1]) begin
            tt = trk_q[j]; th = hit_q[j]; ta = amt_q[j];
            trk_q[j] = trk_q[j-1]; hit_q[j] = hit_q[j-1]; amt_q[j] = amt_q[j-1];
            trk_q[j-1] = tt; hit_q[j-1] = th; amt_q[j-1] = ta;
            j--;
          end
        end
        return;
      end
      if (n == Depth && !(a > amt_q[Depth-1])) return;
      pos = 0;
      while (pos < n && !(a > amt_q[pos])) pos++;
      last = (n < Depth) ? n : Depth - 1;
      for (j = last; j > pos; j--) begin
        trk_q[j] = trk_q[j-1];
        hit_q[j] = hit_q[j-1];
        amt_q[j] = amt_q[j-1];
      end
      trk_q[pos]  = trk;
      hit_q[pos]  = ht;
      amt_q[pos]  = a;
      vld_q[last] = 1'b1;
    endfunction

    function void note_item(func_e f, logic [TrackW-1:0] trk, logic [HitW-1:0] ht,
                            logic [AmountW-1:0] raw);
      longint      a;
      cell_view_t  v;
      int unsigned n;
      a = longint'($signed(raw));
      case (f)
        FUNC_SIGNAL: add_signal(trk, ht, a);
        FUNC_NOISE:  noise_acc = clamp(noise_acc + a, SumMin, SumMax);
        FUNC_ELECT:  elect_acc = clamp(elect_acc + a, SumMin, SumMax);
        default:     clear_cell();
      endcase
      n = held();
      v.top_valid  = (n > 0);
      v.top_track  = (n > 0) ? trk_q[0] : '0;
      v.top_hit    = (n > 0) ? hit_q[0] : '0;
      v.top_amount = (n > 0) ? amt_q[0][AmountW-1:0] : '0;
      v.used       = n[UsedW-1:0];
      v.total      = sig_acc[SumW-1:0];
      v.noise      = noise_acc[SumW-1:0];
      v.elect      = elect_acc[SumW-1:0];
      expected_cells.push_back(v);
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_beat(logic [OutDataW-1:0] d, logic tv);
      cell_view_t e;
      if (expected_cells.size() == 0) begin
        $error("result beat with no pending expectation");
        errors++;
        return;
      end
      e = expected_cells.pop_front();
      cmp("top_valid",    64'(e.top_valid),  64'(tv));
      cmp("top_track",    64'(e.top_track),  64'(d[23:0]));
      cmp("top_hit",      64'(e.top_hit),    64'(d[47:24]));
      cmp("top_amount",   64'(e.top_amount), 64'(d[79:48]));
      cmp("used_entries", 64'(e.used),       64'(d[84:80]));
      cmp("total_signal", 64'(e.total),      64'(d[124:85]));
      cmp("noise_sum",    64'(e.noise),      64'(d[164:125]));
      cmp("elect_sum",    64'(e.elect),      64'(d[204:165]));
    endfunction

    function int unsigned pending();
      return expected_cells.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;   // track, hit, amount
  logic [FuncW-1:0]     s_axis_tuser;   // func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;   // top_track, top_hit, top_amount, used, sums
  logic                 m_axis_tuser;   // top_valid

  cell_scoreboard    sb = new();
  int unsigned       beats_sent;
  int unsigned       burst_left;
  int unsigned       cycles;
  bit                hold_req;
  logic [TrackW-1:0] track_pool [PoolSize];

  ranked_contribution_list_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("ranked_contribution_list_core verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tuser);
  end

  // receiver: random stall modes, plus one long hold-off on request
  initial begin
    int unsigned mode, span;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 80);
      repeat (span) begin
        @(posedge clk_i);
        if (hold_req) begin
          m_axis_tready <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  task automatic send_beat(func_e f, logic [TrackW-1:0] trk, logic [HitW-1:0] ht,
                           logic [AmountW-1:0] amt);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {amt, ht, trk};
    s_axis_tuser  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(f, trk, ht, amt);
    beats_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
  endtask

  function automatic logic [AmountW-1:0] pick_amount();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v = ($urandom_range(0, 16) - 8) * 256;   // coarse values, many ties
        return v[AmountW-1:0];
      end
      4, 5, 6: return $urandom;
      7, 8: begin
        v = $urandom_range(0, 1 << 20);
        if ($urandom_range(0, 1)) v = -v;
        return v[AmountW-1:0];
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
    endcase
  endfunction

  task automatic refresh_pool();
    for (int i = 0; i < PoolSize; i++) track_pool[i] = TrackW'($urandom);
  endtask

  task automatic run_directed();
    send_beat(FUNC_CLEAR,  24'h0,      24'h0,      32'h0);
    send_beat(FUNC_NOISE,  24'hffffff, 24'hffffff, 32'h0);        // empty list
    send_beat(FUNC_SIGNAL, 24'hffffff, 24'hffffff, 32'h7fff_ffff);
    send_beat(FUNC_SIGNAL, 24'h000001, 24'h000000, 32'h8000_0000); // negative, free slot
    send_beat(FUNC_SIGNAL, 24'hffffff, 24'h123456, 32'h0000_0001); // saturate up, keep hit
    send_beat(FUNC_SIGNAL, 24'h000001, 24'habcdef, 32'hffff_ffff); // saturate down
    send_beat(FUNC_SIGNAL, 24'h000002, 24'h000002, 32'h0000_0100);
    send_beat(FUNC_SIGNAL, 24'h000003, 24'h000003, 32'h0000_0100); // tie goes below
    send_beat(FUNC_SIGNAL, 24'h000004, 24'h000004, 32'h0000_0080);
    send_beat(FUNC_SIGNAL, 24'h000002, 24'h000099, 32'hffff_ff80); // re-sort into a tie
    for (int k = 5; k < 10; k++) send_beat(FUNC_SIGNAL, 24'(k), 24'(k), 32'(k * 16));
    send_beat(FUNC_SIGNAL, 24'h00000a, 24'h00000a, 32'h8000_0000); // full, equal to smallest
    send_beat(FUNC_SIGNAL, 24'h00000b, 24'h00000b, 32'hffff_fff0); // full, enters
    send_beat(FUNC_SIGNAL, 24'h00000c, 24'h00000c, 32'h0000_0100);
    send_beat(FUNC_NOISE,  24'h0,      24'h0,      32'h7fff_ffff);
    send_beat(FUNC_NOISE,  24'h0,      24'h0,      32'h8000_0000);
    send_beat(FUNC_ELECT,  24'h0,      24'h0,      32'h7fff_ffff);
    send_beat(FUNC_ELECT,  24'h0,      24'h0,      32'h8000_0000);
    send_beat(FUNC_CLEAR,  24'hffffff, 24'hffffff, 32'hffff_ffff);
  endtask

  task automatic saturation_run(func_e f);
    int unsigned        len;
    logic [AmountW-1:0] amt;
    len = $urandom_range(260, 300);
    amt = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    send_beat(FUNC_CLEAR, TrackW'($urandom), HitW'($urandom), $urandom);
    repeat (len) begin
      send_beat(f, track_pool[$urandom_range(0, PoolSize-1)], HitW'($urandom), amt);
    end
  endtask

  task automatic run_random();
    int unsigned start, idx, r;
    bit          hold_done, sat_sig, sat_noise, sat_elect;
    func_e       f;
    start     = beats_sent;
    hold_done = 1'b0;
    sat_sig   = 1'b0;
    sat_noise = 1'b0;
    sat_elect = 1'b0;
    refresh_pool();
    while (beats_sent - start < RandomItems) begin
      idx = beats_sent - start;
      if (idx >= 500 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (idx >= 100 && !sat_sig) begin
        sat_sig = 1'b1;
        saturation_run(FUNC_SIGNAL);
      end else if (idx >= 700 && !sat_noise) begin
        sat_noise = 1'b1;
        saturation_run(FUNC_NOISE);
      end else if (idx >= 1200 && !sat_elect) begin
        sat_elect = 1'b1;
        saturation_run(FUNC_ELECT);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          f = FUNC_CLEAR;
          if ($urandom_range(0, 1)) refresh_pool();
        end else if (r < 12) f = FUNC_NOISE;
        else if (r < 22) f = FUNC_ELECT;
        else f = FUNC_SIGNAL;
        send_beat(f,
                  ($urandom_range(0, 3) != 0) ? track_pool[$urandom_range(0, PoolSize-1)]
                                              : TrackW'($urandom),
                  HitW'($urandom), pick_amount());
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_SIGNAL;
    hold_req   = 1'b0;
    beats_sent = 0;
    burst_left = 8;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ranked_contribution_list_core verification clean");
    end else begin
      $display("ranked_contribution_list_core verification failed");
    end
    $finish;
  end

endmodule
